>>> sv/bounded_set_store_unit_macros.svh
// Assertion macros shared by the bounded set store RTL.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef BOUNDED_SET_STORE_UNIT_MACROS_SVH
`define BOUNDED_SET_STORE_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define BSS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset.
`define BSS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bss_pkg.sv
// Shared types and constants for the bounded set store.
// No dependencies; imported by bss_cell and bounded_set_store_unit.
package bss_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;
	localparam int ACT_W     = 2;
	localparam int CAP_W     = 5;
	localparam int CNT_OUT_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;

	// Broadcast command to every cell in the commit cycle
	typedef struct packed {
		logic ins;  // load the item value into the tail cell
		logic shf;  // cells at or past the hit take the right neighbour's entry
	} bss_cmd_t;

	// Per-cell occupancy view, derived from the count
	typedef struct packed {
		logic occ;   // cell holds a live entry
		logic more;  // right neighbour holds a live entry
		logic tail;  // first free cell
	} bss_slot_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} bss_state_t;

endpackage

>>> sv/bounded_set_store_unit.sv
// Bounded set store: ordered list of distinct 32-bit values in a chain of cells.
// The result is registered once the search token has left the last cell and the output register is free.
// A new item is taken only while idle, so each item's search finishes before the next is accepted.
// Reset: count cleared, capacity back to 16; stored entries are not cleared.
// Depends on bss_pkg, bss_cell and bounded_set_store_unit_macros.svh.
`include "bounded_set_store_unit_macros.svh"

module bounded_set_store_unit #(
	parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [bss_pkg::CAP_W-1:0]         cfg_wdata,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bss_pkg::ACT_W-1:0]         action,
	input  logic signed [bss_pkg::VAL_W-1:0]  value,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              was_present,
	output logic                              rejected_full,
	output logic [bss_pkg::CNT_OUT_W-1:0]     element_count
);
	import bss_pkg::*;

	// Count must reach DEPTH itself; capacity compare runs at the wider width
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;

	bss_state_t state_q, state_d;

	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [ACT_W-1:0] act_q;
	logic [VAL_W-1:0] val_q;
	logic             start_q;

	logic             out_valid_q;
	logic             present_q;
	logic             rejected_q;
	logic [CNT_OUT_W-1:0] count_out_q;

	// Chain wiring: tok/hit element i feeds cell i and element i+1 comes out; ent element i comes out of cell i
	logic             tok [0:DEPTH];
	logic             hit [0:DEPTH];
	logic [VAL_W-1:0] ent [0:DEPTH];
	logic [DEPTH-1:0] tail_vec;

	bss_cmd_t  cmd;
	bss_slot_t slot [0:DEPTH-1];

	logic accept;
	logic slot_free;
	logic commit;
	logic present;
	logic full;
	logic is_ins;
	logic is_rem;
	logic [EW-1:0] cap_ext;
	logic [EW-1:0] cap_eff;
	logic [EW-1:0] cnt_ext;

	// ---------------------------------------------------------------
	// Capacity register; the user must keep it only written while the block is idle, a rule the block leaves unchecked
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Saturate the configured capacity at the chain length
	assign cap_ext = EW'(cap_q);
	assign cap_eff = (cap_ext > EW'(DEPTH)) ? EW'(DEPTH) : cap_ext;
	assign cnt_ext = EW'(cnt_q);
	assign full    = (cnt_ext >= cap_eff);

	// ---------------------------------------------------------------
	// Control
	// ---------------------------------------------------------------
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// Next state: scan until the token leaves the last cell, then commit
	// as soon as the output register can take the result
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (tok[DEPTH]) begin
					state_d = slot_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State outputs
	always_comb begin
		in_stall = 1'b1;
		commit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_SCAN: begin
				commit = tok[DEPTH] && slot_free;
			end
			ST_HOLD: begin
				commit = slot_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= accept;
		end
	end

	// Hold the item for the whole search
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			val_q <= $unsigned(value);
		end
	end

	// ---------------------------------------------------------------
	// Commit decision
	// ---------------------------------------------------------------
	// The hit flag out of the last cell tells whether the value is held
	assign present = hit[DEPTH];
	assign is_ins  = (act_q == ACT_INSERT);
	assign is_rem  = (act_q == ACT_REMOVE);

	// Full check comes first: a full set rejects even a held value
	assign cmd.ins = commit && is_ins && !full && !present;
	assign cmd.shf = commit && is_rem && present;

	always_comb begin
		cnt_d = cnt_q;
		if (cmd.ins) begin
			cnt_d = cnt_q + 1'b1;
		end else if (cmd.shf) begin
			cnt_d = cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	// ---------------------------------------------------------------
	// Output register; frees the search path while a result waits
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			present_q   <= present;
			rejected_q  <= is_ins && full;
			count_out_q <= CNT_OUT_W'(cnt_d);
		end
	end

	assign out_valid     = out_valid_q;
	assign was_present   = present_q;
	assign rejected_full = rejected_q;
	assign element_count = count_out_q;

	// ---------------------------------------------------------------
	// Cell chain
	// ---------------------------------------------------------------
	// Token enters the head in the cycle after acceptance; the tail end
	// feeds nothing into the last cell's shift input
	assign tok[0]     = start_q;
	assign hit[0]     = 1'b0;
	assign ent[DEPTH] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign slot[i].occ  = (CW'(i) < cnt_q);
		assign slot[i].more = (CW'(i + 1) < cnt_q);
		assign slot[i].tail = (CW'(i) == cnt_q);
		assign tail_vec[i]  = slot[i].tail;

		bss_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.slot       (slot[i]),
			.value      (val_q),
			.tok_in     (tok[i]),
			.hit_in     (hit[i]),
			.next_entry (ent[i + 1]),
			.tok_q      (tok[i + 1]),
			.hit_q      (hit[i + 1]),
			.entry_q    (ent[i])
		);
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`BSS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "count exceeds depth")
	`BSS_ASSERT_IMP(a_ins_not_full, cmd.ins, !full && tail_vec != '0, "insert into full set")
	`BSS_ASSERT_IMP(a_one_tail, 1'b1, $onehot0(tail_vec), "more than one tail cell")
	`BSS_ASSERT_NXT(a_rem_dec, cmd.shf, cnt_q == CW'($past(cnt_q) - 1'b1), "remove lost count")

endmodule

>>> sv/bss_cell.sv
// One storage cell of the set chain: entry, search token and hit flag.
// Depends on bss_pkg.
module bss_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bss_pkg::bss_cmd_t       cmd,
	input  bss_pkg::bss_slot_t      slot,
	input  logic [bss_pkg::VAL_W-1:0] value,
	input  logic                    tok_in,
	input  logic                    hit_in,
	input  logic [bss_pkg::VAL_W-1:0] next_entry,
	output logic                    tok_q,
	output logic                    hit_q,
	output logic [bss_pkg::VAL_W-1:0] entry_q
);
	import bss_pkg::*;

	logic match;

	assign match = slot.occ && (entry_q == value);

	// Token walks one cell a cycle; hit marks a match here or further left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (tok_in) begin
				hit_q <= hit_in | match;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && slot.tail) begin
			entry_q <= value;
		end else if (cmd.shf && hit_q && slot.more) begin
			entry_q <= next_entry;
		end
	end

endmodule
